FILE: hdl/mtrr_pkg.sv
// Shared constants and types of the memory-type range resolver.
`timescale 1ns / 1ps
package mtrr_pkg;

  localparam int NUM_RANGES   = 16;
  localparam int ADDR_BITS    = 48;
  localparam int PAGE_SHIFT   = 12;
  localparam int REGION_SHIFT = 21;
  localparam int FRAME_BITS   = 36;
  localparam int IDX_W        = 4;
  localparam int TYPE_W       = 3;

  localparam logic [TYPE_W-1:0]    DEFAULT_TYPE_RST = TYPE_W'(6);
  localparam logic [ADDR_BITS-1:0] TOP_ADDR         = {ADDR_BITS{1'b1}};
  localparam logic [ADDR_BITS-1:0] REGION_M1 =
    ADDR_BITS'((64'd1 << REGION_SHIFT) - 64'd1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Bounds as kept in the table: the low bound is pre-lowered by the region
  // span minus one so a query compares its start address only.
  typedef struct packed {
    logic [ADDR_BITS-1:0] low_adj;
    logic [ADDR_BITS-1:0] high;
  } bounds_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic              enabled;
    logic [TYPE_W-1:0] mem_type;
    bounds_t           bounds;
  } wr_req_t;

endpackage

FILE: hdl/mtrr_bound_calc.sv
// Range bound computation for a load: low bound, high bound, saturation.
`timescale 1ns / 1ps
module mtrr_bound_calc (
  input  logic [mtrr_pkg::FRAME_BITS-1:0] base_frame,
  input  logic [mtrr_pkg::FRAME_BITS-1:0] mask_frame,
  output mtrr_pkg::bounds_t               bounds
);
  import mtrr_pkg::*;

  logic [FRAME_BITS-1:0] below;
  logic [ADDR_BITS-1:0]  low;
  logic [ADDR_BITS-1:0]  span_m1;
  logic [ADDR_BITS:0]    high_ext;
  logic [ADDR_BITS:0]    adj_ext;

  // Ones at every mask bit below the lowest set one.
  assign below   = ~mask_frame & (mask_frame - FRAME_BITS'(1));
  assign low     = ADDR_BITS'({base_frame, {PAGE_SHIFT{1'b0}}});
  assign span_m1 = ADDR_BITS'({below, {PAGE_SHIFT{1'b1}}});

  assign high_ext = {1'b0, low} + {1'b0, span_m1};
  assign adj_ext  = {1'b0, low} - {1'b0, REGION_M1};

  always_comb begin
    // Zero mask or carry out of the top saturates the window.
    if (mask_frame == '0 || high_ext[ADDR_BITS]) begin
      bounds.high = TOP_ADDR;
    end else begin
      bounds.high = high_ext[ADDR_BITS-1:0];
    end
    // Clamp at zero when the low bound lies within one region of the bottom.
    if (adj_ext[ADDR_BITS]) begin
      bounds.low_adj = '0;
    end else begin
      bounds.low_adj = adj_ext[ADDR_BITS-1:0];
    end
  end

endmodule

FILE: hdl/mtrr_range_table.sv
// Range entry table with per-entry overlap compare and last-match select.
`timescale 1ns / 1ps
module mtrr_range_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mtrr_pkg::wr_req_t             wr,
  input  logic [mtrr_pkg::ADDR_BITS-1:0] query_start,
  input  logic [mtrr_pkg::TYPE_W-1:0]   default_type,
  output logic [mtrr_pkg::TYPE_W-1:0]   res_type,
  output logic                          matched
);
  import mtrr_pkg::*;

  logic [NUM_RANGES-1:0] enabled_r;
  logic [TYPE_W-1:0]     type_r   [NUM_RANGES];
  bounds_t               bounds_r [NUM_RANGES];
  logic [NUM_RANGES-1:0] hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= '0;
    end else begin
      for (int i = 0; i < NUM_RANGES; i++) begin
        if (wr.we && wr.idx == IDX_W'(i)) begin
          enabled_r[i] <= wr.enabled;
        end
      end
    end
  end

  // A disabled load leaves the bounds alone; they are never looked at.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (wr.we && wr.idx == IDX_W'(i)) begin
        type_r[i] <= wr.mem_type;
        if (wr.enabled) begin
          bounds_r[i] <= wr.bounds;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_RANGES; i++) begin
      hit[i] = enabled_r[i] && (query_start >= bounds_r[i].low_adj) &&
               (query_start <= bounds_r[i].high);
    end
  end

  // Highest-numbered hit wins.
  always_comb begin
    res_type = default_type;
    matched  = 1'b0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (hit[i]) begin
        res_type = type_r[i];
        matched  = 1'b1;
      end
    end
  end

endmodule

FILE: hdl/mtrr_memory_type_resolver_top.sv
// Top level of the memory-type range resolver: handshakes, stages, config.
`timescale 1ns / 1ps
// Resolves the memory type of a 2 MB physical region against sixteen variable
// ranges. A load transaction (operation 0) writes one range entry and returns
// a zero result; a query transaction (operation 1) returns the type of the
// highest-numbered enabled range overlapping the region, or the default type
// with matched low. One transaction is accepted per cycle unless in_stall is high;
// each passes an input register, one level of bound or compare logic and an
// output register that holds its result. Loads write the table as they leave
// the input register, so a following query sees them.
// The default type register resets to write-back (6) and is always ready.
module mtrr_memory_type_resolver_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [mtrr_pkg::IDX_W-1:0]     in_entry_index,
  input  logic                           in_range_valid,
  input  logic [mtrr_pkg::TYPE_W-1:0]    in_range_type,
  input  logic [mtrr_pkg::FRAME_BITS-1:0] in_base_frame,
  input  logic [mtrr_pkg::FRAME_BITS-1:0] in_mask_frame,
  input  logic [mtrr_pkg::ADDR_BITS-1:0] in_query_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mtrr_pkg::TYPE_W-1:0]    out_memory_type,
  output logic                           out_matched,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mtrr_pkg::TYPE_W-1:0]    cfg_default_memory_type
);
  import mtrr_pkg::*;

  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic                  s1_en_r;
  logic [TYPE_W-1:0]     s1_type_r;
  logic [FRAME_BITS-1:0] s1_base_r;
  logic [FRAME_BITS-1:0] s1_mask_r;
  logic [ADDR_BITS-1:0]  s1_addr_r;

  logic                  out_valid_r;
  logic [TYPE_W-1:0]     out_type_r;
  logic                  out_matched_r;
  logic [TYPE_W-1:0]     default_type_r;

  logic                  out_free;
  logic                  s1_adv;
  logic                  in_take;
  bounds_t               bounds;
  wr_req_t               wr;
  logic [TYPE_W-1:0]     q_type;
  logic                  q_matched;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_type_r <= DEFAULT_TYPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      default_type_r <= cfg_default_memory_type;
    end
  end

  // Input register: hold while the output stage is blocked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_operation;
      s1_idx_r  <= in_entry_index;
      s1_en_r   <= in_range_valid;
      s1_type_r <= in_range_type;
      s1_base_r <= in_base_frame;
      s1_mask_r <= in_mask_frame;
      s1_addr_r <= in_query_address;
    end
  end

  mtrr_bound_calc u_bound_calc (
    .base_frame (s1_base_r),
    .mask_frame (s1_mask_r),
    .bounds     (bounds)
  );

  always_comb begin
    wr.we       = s1_adv && (s1_op_r == OP_LOAD);
    wr.idx      = s1_idx_r;
    wr.enabled  = s1_en_r;
    wr.mem_type = s1_type_r;
    wr.bounds   = bounds;
  end

  mtrr_range_table u_range_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr           (wr),
    .query_start  (s1_addr_r),
    .default_type (default_type_r),
    .res_type     (q_type),
    .matched      (q_matched)
  );

  // Output register: advance when empty or taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_op_r == OP_QUERY) begin
        out_type_r    <= q_type;
        out_matched_r <= q_matched;
      end else begin
        out_type_r    <= '0;
        out_matched_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_memory_type = out_type_r;
  assign out_matched     = out_matched_r;

endmodule

FILE: dv/mtrr_memory_type_resolver_top_test.sv
// Self-checking testbench for the memory-type range resolver top level.
`timescale 1ns / 1ps
module mtrr_memory_type_resolver_top_test;
  import mtrr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [63:0] REGION_SPAN = 64'd1 << REGION_SHIFT;

  typedef struct {
    logic                  operation;
    logic [IDX_W-1:0]      entry_index;
    logic                  range_valid;
    logic [TYPE_W-1:0]     range_type;
    logic [FRAME_BITS-1:0] base_frame;
    logic [FRAME_BITS-1:0] mask_frame;
    logic [ADDR_BITS-1:0]  query_address;
  } range_request_t;

  typedef struct {
    logic [TYPE_W-1:0] mem_type;
    logic              matched;
  } type_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_operation = 1'b0;
  logic [IDX_W-1:0]      in_entry_index = '0;
  logic                  in_range_valid = 1'b0;
  logic [TYPE_W-1:0]     in_range_type = '0;
  logic [FRAME_BITS-1:0] in_base_frame = '0;
  logic [FRAME_BITS-1:0] in_mask_frame = '0;
  logic [ADDR_BITS-1:0]  in_query_address = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TYPE_W-1:0]     out_memory_type;
  logic                  out_matched;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [TYPE_W-1:0]     cfg_default_memory_type = DEFAULT_TYPE_RST;

  mtrr_memory_type_resolver_top dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_operation            (in_operation),
    .in_entry_index          (in_entry_index),
    .in_range_valid          (in_range_valid),
    .in_range_type           (in_range_type),
    .in_base_frame           (in_base_frame),
    .in_mask_frame           (in_mask_frame),
    .in_query_address        (in_query_address),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_memory_type         (out_memory_type),
    .out_matched             (out_matched),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_default_memory_type (cfg_default_memory_type)
  );

  // Predicted table and default type
  logic                 range_on   [NUM_RANGES];
  logic [TYPE_W-1:0]    range_kind [NUM_RANGES];
  logic [ADDR_BITS-1:0] range_low  [NUM_RANGES];
  logic [ADDR_BITS-1:0] range_high [NUM_RANGES];
  logic [TYPE_W-1:0]    default_type_model;

  // Bounds known while generating stimulus, used to aim queries at edges
  logic [ADDR_BITS-1:0] planned_low  [NUM_RANGES];
  logic [ADDR_BITS-1:0] planned_high [NUM_RANGES];

  range_request_t pending_requests[$];
  type_result_t   expected_types[$];
  range_request_t presented;
  int             results_due = 0;
  int             errors = 0;
  int             in_gap_pct = 0;
  int             out_stall_pct = 0;
  int             gap_left = 0;
  int             stall_left = 0;
  int             quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [ADDR_BITS-1:0] range_high_bound(logic [ADDR_BITS-1:0] low,
                                                            logic [FRAME_BITS-1:0] mask);
    int          k;
    logic [63:0] high;
    if (mask == '0) return TOP_ADDR;
    k = 0;
    while (mask[k] == 1'b0) k++;
    k += PAGE_SHIFT;
    if (k >= ADDR_BITS) return TOP_ADDR;
    high = 64'(low) + (64'd1 << k) - 64'd1;
    if (high > 64'(TOP_ADDR)) return TOP_ADDR;
    return high[ADDR_BITS-1:0];
  endfunction

  function automatic logic [ADDR_BITS-1:0] frame_to_address(logic [FRAME_BITS-1:0] frame);
    logic [63:0] wide;
    wide = 64'(frame) << PAGE_SHIFT;
    return wide[ADDR_BITS-1:0];
  endfunction

  // Apply one transaction to the predicted table and return its result
  function automatic type_result_t resolve_memory_type(range_request_t r);
    type_result_t res;
    logic [63:0]  first_addr;
    logic [63:0]  last_addr;
    res.mem_type = '0;
    res.matched  = 1'b0;
    if (r.operation == OP_LOAD) begin
      if (int'(r.entry_index) < NUM_RANGES) begin
        range_on[r.entry_index]   = r.range_valid;
        range_kind[r.entry_index] = r.range_type;
        if (r.range_valid) begin
          range_low[r.entry_index]  = frame_to_address(r.base_frame);
          range_high[r.entry_index] = range_high_bound(range_low[r.entry_index], r.mask_frame);
        end
      end
    end else begin
      // region end without wrap
      first_addr   = 64'(r.query_address);
      last_addr    = first_addr + REGION_SPAN - 64'd1;
      res.mem_type = default_type_model;
      for (int i = 0; i < NUM_RANGES; i++) begin
        if (range_on[i] && last_addr >= 64'(range_low[i]) &&
            first_addr <= 64'(range_high[i])) begin
          res.mem_type = range_kind[i];
          res.matched  = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic range_request_t random_request();
    range_request_t r;
    r.operation     = 1'($urandom);
    r.entry_index   = IDX_W'($urandom);
    r.range_valid   = 1'($urandom);
    r.range_type    = TYPE_W'($urandom);
    r.base_frame    = FRAME_BITS'({$urandom, $urandom});
    r.mask_frame    = FRAME_BITS'({$urandom, $urandom});
    r.query_address = ADDR_BITS'({$urandom, $urandom});
    return r;
  endfunction

  task automatic queue_request(range_request_t r);
    if (r.operation == OP_LOAD && int'(r.entry_index) < NUM_RANGES) begin
      if (r.range_valid) begin
        planned_low[r.entry_index]  = frame_to_address(r.base_frame);
        planned_high[r.entry_index] = range_high_bound(planned_low[r.entry_index], r.mask_frame);
      end
    end
    results_due++;
    pending_requests.push_back(r);
  endtask

  task automatic queue_load(logic [IDX_W-1:0] idx, logic valid, logic [TYPE_W-1:0] kind,
                            logic [FRAME_BITS-1:0] base, logic [FRAME_BITS-1:0] mask);
    range_request_t r;
    r = '{OP_LOAD, idx, valid, kind, base, mask, '0};
    queue_request(r);
  endtask

  task automatic queue_query(logic [ADDR_BITS-1:0] addr);
    range_request_t r;
    r = '{OP_QUERY, '0, 1'b0, '0, '0, '0, addr};
    queue_request(r);
  endtask

  task automatic queue_random_requests(int count);
    range_request_t       r;
    logic [IDX_W-1:0]     ix;
    logic [ADDR_BITS-1:0] lo;
    logic [ADDR_BITS-1:0] hi;
    int                   j;
    for (int n = 0; n < count; n++) begin
      r = random_request();
      if ($urandom_range(99) < 35) begin
        r.operation   = OP_LOAD;
        r.range_valid = ($urandom_range(3) != 0);
        case ($urandom_range(3))
          0: r.base_frame = FRAME_BITS'($urandom_range(4095));
          1: r.base_frame = {FRAME_BITS{1'b1}} - FRAME_BITS'($urandom_range(255));
          default: ;
        endcase
        // mostly contiguous masks as real range registers use
        j = $urandom_range(FRAME_BITS - 1);
        case ($urandom_range(5))
          0: r.mask_frame = '0;
          1: ;
          2: begin
            r.mask_frame = {FRAME_BITS{1'b1}} << j;
            r.base_frame = r.base_frame & r.mask_frame;
          end
          default: r.mask_frame = {FRAME_BITS{1'b1}} << j;
        endcase
      end else begin
        r.operation = OP_QUERY;
        ix = IDX_W'($urandom);
        lo = planned_low[ix];
        hi = planned_high[ix];
        case ($urandom_range(11))
          0: r.query_address = lo - ADDR_BITS'(REGION_SPAN);
          1: r.query_address = lo - ADDR_BITS'(REGION_SPAN) + ADDR_BITS'(1);
          2: r.query_address = lo;
          3: r.query_address = hi;
          4: r.query_address = hi + ADDR_BITS'(1);
          5: r.query_address = lo + ADDR_BITS'($urandom_range(32'hFFFF_FFFF));
          6: r.query_address = TOP_ADDR - ADDR_BITS'($urandom_range(1 << (REGION_SHIFT + 1)));
          7: r.query_address = ADDR_BITS'($urandom_range(1 << (REGION_SHIFT + 2)));
          8: r.query_address = r.query_address & ~ADDR_BITS'(REGION_M1);
          default: ;
        endcase
      end
      queue_request(r);
    end
  endtask

  task automatic wait_all_results();
    while (results_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_default_type(logic [TYPE_W-1:0] value);
    @(posedge clk);
    cfg_valid               <= 1'b1;
    cfg_default_memory_type <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    default_type_model = value;
    cfg_valid          <= 1'b0;
  endtask

  // Input driver: hold the payload while stalled, advance on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) expected_types.push_back(resolve_memory_type(presented));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0 && $urandom_range(99) < in_gap_pct) begin
          gap_left <= $urandom_range(8);
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          presented = pending_requests.pop_front();
          in_valid         <= 1'b1;
          in_operation     <= presented.operation;
          in_entry_index   <= presented.entry_index;
          in_range_valid   <= presented.range_valid;
          in_range_type    <= presented.range_type;
          in_base_frame    <= presented.base_frame;
          in_mask_frame    <= presented.mask_frame;
          in_query_address <= presented.query_address;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(99) < out_stall_pct) begin
      stall_left <= $urandom_range(8);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    type_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_types.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual type %0d matched %0d",
                 $time, out_memory_type, out_matched);
        errors++;
      end else begin
        want = expected_types.pop_front();
        results_due--;
        if (out_memory_type !== want.mem_type) begin
          $display("%0t: memory type mismatch, expected %0d, actual %0d",
                   $time, want.mem_type, out_memory_type);
          errors++;
        end
        if (out_matched !== want.matched) begin
          $display("%0t: matched mismatch, expected %0d, actual %0d",
                   $time, want.matched, out_matched);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with work outstanding and no transaction moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || (results_due == 0 && !cfg_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, results_due);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NUM_RANGES; i++) begin
      range_on[i]     = 1'b0;
      range_kind[i]   = '0;
      range_low[i]    = '0;
      range_high[i]   = '0;
      planned_low[i]  = '0;
      planned_high[i] = '0;
    end
    default_type_model = DEFAULT_TYPE_RST;
    in_gap_pct    = 20;
    out_stall_pct = 20;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty table gives the default type
    queue_query('0);
    queue_query(TOP_ADDR);
    // zero mask covers the whole space; the region at the top must not wrap
    queue_load(4'd0, 1'b1, 3'd0, '0, '0);
    queue_query(TOP_ADDR);
    // disabled load: bounds stay but are never used
    queue_load(4'd0, 1'b0, 3'd2, 36'h0_0000_1234, 36'hF_FFFF_F000);
    queue_query(TOP_ADDR);
    // single page at the very top
    queue_load(4'd15, 1'b1, 3'd7, {FRAME_BITS{1'b1}}, {FRAME_BITS{1'b1}});
    queue_query(TOP_ADDR - REGION_M1);
    queue_query('0);
    // huge range near the top overflows and saturates
    queue_load(4'd6, 1'b1, 3'd5, 36'hF_FFFF_0000, 36'h8_0000_0000);
    queue_query(48'hFFFF_0000_0000);
    queue_query(TOP_ADDR);
    // 4 KB range: region edges just outside and inside
    queue_load(4'd9, 1'b1, 3'd4, 36'h0_0001_2345, {FRAME_BITS{1'b1}});
    queue_query(48'h0000_1214_5000);
    queue_query(48'h0000_1214_5001);
    queue_query(48'h0000_1234_5FFF);
    queue_query(48'h0000_1234_6000);
    // largest non-saturating size, then overlap with the higher entry
    queue_load(4'd3, 1'b1, 3'd1, 36'h0_0000_0100, 36'h8_0000_0000);
    queue_query(48'h8000_0010_0000);
    queue_query(48'h8000_000F_FFFF);
    queue_query(48'h0000_1234_5000);
    wait_all_results();

    write_default_type(3'd0);
    in_gap_pct    = 30;
    out_stall_pct = 10;
    queue_random_requests(475);
    wait_all_results();

    write_default_type(3'd7);
    in_gap_pct    = 5;
    out_stall_pct = 40;
    queue_random_requests(475);
    wait_all_results();

    write_default_type(TYPE_W'($urandom_range(5, 1)));
    in_gap_pct    = 15;
    out_stall_pct = 15;
    queue_random_requests(475);
    wait_all_results();

    // closing stretch at full rate
    write_default_type(DEFAULT_TYPE_RST);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    queue_random_requests(475);
    wait_all_results();
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mtrr_pkg.sv
hdl/mtrr_bound_calc.sv
hdl/mtrr_range_table.sv
hdl/mtrr_memory_type_resolver_top.sv
dv/mtrr_memory_type_resolver_top_test.sv
